[rtl/core/dms_pkg.sv]
// Shared types, codes and constants of the drive move supervisor.
package dms_pkg;

	// Item kinds (slave tuser)
	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_ENC  = 2'd1;
	localparam logic [1:0] KIND_GYRO = 2'd2;
	localparam logic [1:0] KIND_OBST = 2'd3;

	// Command ops; OP_STOP doubles as the idle code of the running op
	localparam logic [2:0] OP_FWD   = 3'd0;
	localparam logic [2:0] OP_BACK  = 3'd1;
	localparam logic [2:0] OP_RIGHT = 3'd2;
	localparam logic [2:0] OP_LEFT  = 3'd3;
	localparam logic [2:0] OP_STOP  = 3'd4;
	localparam logic [2:0] OP_IDLE  = 3'd4;

	// Reply codes
	localparam logic [2:0] RC_NONE    = 3'd0;
	localparam logic [2:0] RC_SUCCESS = 3'd1;
	localparam logic [2:0] RC_SKIPPED = 3'd2;
	localparam logic [2:0] RC_BLOCKED = 3'd3;
	localparam logic [2:0] RC_INVALID = 3'd4;
	localparam logic [2:0] RC_MISSING = 3'd5;

	// Direction enables: bit0 right fwd, bit1 right back, bit2 left fwd, bit3 left back
	localparam logic [3:0] DRIVE_FWD   = 4'd5;
	localparam logic [3:0] DRIVE_BACK  = 4'd10;
	localparam logic [3:0] DRIVE_RIGHT = 4'd6;
	localparam logic [3:0] DRIVE_LEFT  = 4'd9;
	localparam logic [3:0] DRIVE_OFF   = 4'd0;

	// Register indexes
	localparam logic [0:0] REG_PPU  = 1'd0;
	localparam logic [0:0] REG_BIAS = 1'd1;

	localparam logic [7:0]  PPU_RESET  = 8'd20;
	localparam logic [10:0] BIAS_RESET = 11'd61;

	// 131 LSB per deg/s times 1000 ms per s
	localparam logic [16:0] ANGLE_SCALE = 17'd131000;

	// Shared unit step counts
	localparam int DIV_STEPS = 32;
	localparam int MUL_STEPS = 16;

	typedef struct packed {
		logic [7:0]         pulses_per_unit;
		logic signed [10:0] rate_bias;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         command_op;
		logic [15:0]        amount;
		logic               want_reply;
		logic               encoder_side;
		logic signed [15:0] gyro_rate;
		logic [9:0]         elapsed_ms;
		logic               obstacle;
	} item_t;

	typedef struct packed {
		logic [3:0]  drive;
		logic [2:0]  reply_code;
		logic [15:0] moved;
		logic        last;
	} res_t;

	// MUL: y * x[15:0]; DIV: x / y, quotient saturated to 16 bits
	typedef struct packed {
		logic        start;
		logic        div;
		logic [47:0] x;
		logic [16:0] y;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] value;
	} alu_rsp_t;

	function automatic logic [3:0] drive_of(input logic [2:0] op);
		logic [3:0] d;
		unique case (op)
			OP_FWD:   d = DRIVE_FWD;
			OP_BACK:  d = DRIVE_BACK;
			OP_RIGHT: d = DRIVE_RIGHT;
			OP_LEFT:  d = DRIVE_LEFT;
			default:  d = DRIVE_OFF;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/dms_alu.sv]
// Shared shift-add multiplier and shift-subtract divider, one bit per cycle.
module dms_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  dms_pkg::alu_req_t req,
	output dms_pkg::alu_rsp_t rsp
);
	import dms_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic [4:0]  cnt_q;
	logic [48:0] acc_q;
	logic [47:0] sh_q;
	logic [31:0] bits_q;

	logic [48:0] addend;
	logic [48:0] sum;
	logic        ge;
	logic [15:0] quot_sat;

	// One adder: add for multiply, subtract for divide
	assign addend = div_q ? ~{1'b0, sh_q} : {1'b0, sh_q};
	assign sum    = acc_q + addend + 49'(div_q);
	assign ge     = !sum[48];

	assign quot_sat = (|bits_q[31:16]) ? 16'hFFFF : bits_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= req.div;
				cnt_q  <= req.div ? 5'(DIV_STEPS - 1) : 5'(MUL_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.div) begin
				acc_q  <= {1'b0, req.x};
				sh_q   <= {req.y, 31'd0};
				bits_q <= '0;
			end else begin
				acc_q  <= '0;
				sh_q   <= {31'd0, req.y};
				bits_q <= {16'd0, req.x[15:0]};
			end
		end else if (busy_q) begin
			if (div_q) begin
				if (ge)
					acc_q <= sum;
				bits_q <= {bits_q[30:0], ge};
				sh_q   <= sh_q >> 1;
			end else begin
				if (bits_q[0])
					acc_q <= sum;
				bits_q <= bits_q >> 1;
				sh_q   <= sh_q << 1;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = div_q ? {17'd0, quot_sat} : acc_q[32:0];

endmodule

[rtl/core/dms_ctrl.sv]
// Sequencer: holds the move state, steps the shared unit and lines up replies.
module dms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  dms_pkg::cfg_t     cfg,
	input  logic              take,
	input  dms_pkg::item_t    item,
	output logic              idle,
	output dms_pkg::alu_req_t req,
	input  dms_pkg::alu_rsp_t rsp,
	output logic              res_valid,
	output dms_pkg::res_t     res
);
	import dms_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_SKIP     = 4'd2;
	localparam logic [3:0] ST_START    = 4'd3;
	localparam logic [3:0] ST_GOAL     = 4'd4;
	localparam logic [3:0] ST_YAW      = 4'd5;
	localparam logic [3:0] ST_CHECK    = 4'd6;
	localparam logic [3:0] ST_BLOCK    = 4'd7;
	localparam logic [3:0] ST_EMIT     = 4'd8;

	logic [3:0]  state_q, state_nxt;
	item_t       item_q;
	logic [2:0]  act_q;
	logic        want_q;
	logic        obst_q;
	logic [31:0] right_q, left_q;
	logic [23:0] goal_q;
	logic [32:0] thr_q;
	logic [47:0] yaw_q;
	logic [2:0]  pcode_q [2];
	logic [15:0] pmoved_q [2];
	logic [1:0]  pn_q;
	logic        ek_q;

	logic        halt_c, go_c, push_c;
	logic [2:0]  pcode_c;
	logic [15:0] pmoved_c;
	logic [7:0]  ppu_eff;
	logic [47:0] dist_num;
	logic [16:0] diff, mag;
	logic [48:0] yaw_sum;
	logic        is_move, is_turn, goal_hit, yaw_hit, emit_last;

	assign ppu_eff  = (cfg.pulses_per_unit == '0) ? 8'd1 : cfg.pulses_per_unit;
	assign dist_num = 48'((33'(right_q) + 33'(left_q)) >> 1);
	assign diff     = {item_q.gyro_rate[15], item_q.gyro_rate}
	                - {{6{cfg.rate_bias[10]}}, cfg.rate_bias};
	assign mag      = diff[16] ? (~diff + 17'd1) : diff;
	assign yaw_sum  = {1'b0, yaw_q} + 49'(rsp.value[26:0]);

	assign is_move  = (act_q == OP_FWD) || (act_q == OP_BACK);
	assign is_turn  = (act_q == OP_RIGHT) || (act_q == OP_LEFT);
	assign goal_hit = is_move && (right_q >= 32'(goal_q)) && (left_q >= 32'(goal_q));
	assign yaw_hit  = is_turn && (yaw_q >= 48'(thr_q));
	assign emit_last = (2'(ek_q) + 2'd1 == pn_q);

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		halt_c    = 1'b0;
		go_c      = 1'b0;
		push_c    = 1'b0;
		pcode_c   = RC_NONE;
		pmoved_c  = '0;
		req       = '0;
		res_valid = 1'b0;
		res       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take)
					state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (item_q.kind)
					KIND_CMD: begin
						if ((is_move || is_turn) && want_q) begin
							req.start = 1'b1;
							req.div   = 1'b1;
							req.x     = is_move ? dist_num : yaw_q;
							req.y     = is_move ? {9'd0, ppu_eff} : ANGLE_SCALE;
							state_nxt = ST_SKIP;
						end else begin
							state_nxt = ST_START;
						end
					end
					KIND_GYRO: begin
						req.start = 1'b1;
						req.x     = {38'd0, item_q.elapsed_ms};
						req.y     = mag;
						state_nxt = ST_YAW;
					end
					default: state_nxt = ST_CHECK;
				endcase
			end
			ST_SKIP: begin
				if (rsp.done) begin
					push_c    = 1'b1;
					pcode_c   = RC_SKIPPED;
					pmoved_c  = rsp.value[15:0];
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				halt_c    = 1'b1;
				state_nxt = ST_EMIT;
				priority if (item_q.command_op > OP_STOP) begin
					push_c  = 1'b1;
					pcode_c = RC_INVALID;
				end else if (item_q.command_op != OP_STOP && item_q.amount == '0) begin
					push_c  = 1'b1;
					pcode_c = RC_MISSING;
				end else if (item_q.command_op == OP_FWD && obst_q) begin
					push_c  = item_q.want_reply;
					pcode_c = RC_BLOCKED;
				end else if (item_q.command_op == OP_STOP) begin
					push_c  = item_q.want_reply;
					pcode_c = RC_SUCCESS;
				end else begin
					// Start the move or turn; work out its goal on the shared unit
					go_c      = 1'b1;
					req.start = 1'b1;
					req.x     = {32'd0, item_q.amount};
					req.y     = (item_q.command_op <= OP_BACK) ? {9'd0, ppu_eff} : ANGLE_SCALE;
					state_nxt = ST_GOAL;
				end
			end
			ST_GOAL: begin
				if (rsp.done)
					state_nxt = ST_EMIT;
			end
			ST_YAW: begin
				if (rsp.done)
					state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = ST_EMIT;
				priority if (goal_hit) begin
					push_c  = want_q;
					pcode_c = RC_SUCCESS;
					halt_c  = 1'b1;
				end else if (act_q == OP_FWD && obst_q) begin
					if (want_q) begin
						req.start = 1'b1;
						req.div   = 1'b1;
						req.x     = dist_num;
						req.y     = {9'd0, ppu_eff};
						state_nxt = ST_BLOCK;
					end else begin
						halt_c = 1'b1;
					end
				end else if (yaw_hit) begin
					push_c  = want_q;
					pcode_c = RC_SUCCESS;
					halt_c  = 1'b1;
				end else begin
					state_nxt = ST_EMIT;
				end
			end
			ST_BLOCK: begin
				if (rsp.done) begin
					push_c    = 1'b1;
					pcode_c   = RC_BLOCKED;
					pmoved_c  = rsp.value[15:0];
					halt_c    = 1'b1;
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				res_valid   = 1'b1;
				res.drive   = drive_of(act_q);
				if (pn_q == '0) begin
					res.reply_code = RC_NONE;
					res.moved      = '0;
					res.last       = 1'b1;
					state_nxt      = ST_IDLE;
				end else begin
					res.reply_code = pcode_q[ek_q];
					res.moved      = pmoved_q[ek_q];
					res.last       = emit_last;
					if (emit_last)
						state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= OP_IDLE;
			want_q  <= 1'b0;
			obst_q  <= 1'b0;
			right_q <= '0;
			left_q  <= '0;
			goal_q  <= '0;
			thr_q   <= '0;
			yaw_q   <= '0;
			pn_q    <= '0;
			ek_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (halt_c) begin
				act_q   <= OP_IDLE;
				want_q  <= 1'b0;
				right_q <= '0;
				left_q  <= '0;
				goal_q  <= '0;
				thr_q   <= '0;
				yaw_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pn_q <= '0;
					ek_q <= 1'b0;
				end
				ST_DISPATCH: begin
					if (item_q.kind == KIND_ENC) begin
						if (item_q.encoder_side) begin
							if (left_q != '1)
								left_q <= left_q + 32'd1;
						end else begin
							if (right_q != '1)
								right_q <= right_q + 32'd1;
						end
					end else if (item_q.kind == KIND_OBST) begin
						obst_q <= item_q.obstacle;
					end
				end
				ST_START: begin
					if (go_c) begin
						act_q  <= item_q.command_op;
						want_q <= item_q.want_reply;
					end
				end
				ST_GOAL: begin
					if (rsp.done) begin
						if (is_move)
							goal_q <= rsp.value[23:0];
						else
							thr_q <= rsp.value;
					end
				end
				ST_YAW: begin
					if (rsp.done)
						yaw_q <= yaw_sum[48] ? '1 : yaw_sum[47:0];
				end
				ST_EMIT: begin
					if (pn_q != '0 && !emit_last)
						ek_q <= 1'b1;
				end
				default: ;
			endcase
			if (push_c)
				pn_q <= pn_q + 2'd1;
		end
	end

	// Item and reply slots hold payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take)
			item_q <= item;
		if (push_c) begin
			pcode_q[pn_q[0]]  <= pcode_c;
			pmoved_q[pn_q[0]] <= pmoved_c;
		end
	end

endmodule

[rtl/core/drive_move_supervisor_top.sv]
// Top level of the drive move supervisor: config registers, result queue, sequencer, shared unit.
// An encoder edge needs no work on the shared unit; an obstacle update needs a divide only when it
// blocks a forward move that wants a reply; a gyro sample needs a multiply; a command needs at most a
// divide for the skipped reply plus a multiply for the new goal, on the one-bit-per-cycle shared unit.
// One item at a time: the next is taken once the sequencer is idle and the queue has room.
// Reset (arst_n low): move state cleared, pulses_per_unit 20, rate_bias 61, queue empty.
module drive_move_supervisor_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// command_op[2:0], amount[18:3], want_reply[19], encoder_side[20],
	// gyro_rate[36:21], elapsed_ms[46:37], obstacle[47]
	input  logic [47:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// drive[3:0], reply_code[6:4], moved[22:7], zero pad[23]
	output logic [23:0] m_tdata,
	output logic        m_tlast
);
	import dms_pkg::*;

	// Result queue deep enough for two waiting results plus the two of the next item
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	cfg_t      cfg_q;
	item_t     item;
	alu_req_t  alu_req;
	alu_rsp_t  alu_rsp;
	logic      ctrl_idle;
	logic      res_valid;
	res_t      res;
	logic      take;
	logic      pop;

	res_t           q_mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;
	res_t           q_head;

	// Config registers: the user must write them only while the block sits idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulses_per_unit <= PPU_RESET;
			cfg_q.rate_bias       <= BIAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PPU:  cfg_q.pulses_per_unit <= cfg_data[7:0];
				REG_BIAS: cfg_q.rate_bias       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the slave side
	assign item.kind         = s_tuser;
	assign item.command_op   = s_tdata[2:0];
	assign item.amount       = s_tdata[18:3];
	assign item.want_reply   = s_tdata[19];
	assign item.encoder_side = s_tdata[20];
	assign item.gyro_rate    = s_tdata[36:21];
	assign item.elapsed_ms   = s_tdata[46:37];
	assign item.obstacle     = s_tdata[47];

	// Take an item only with room for both of its possible results
	assign s_tready = ctrl_idle && (cnt_q <= (QAW+1)'(QDEPTH - 2));
	assign take     = s_tvalid && s_tready;

	dms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.take      (take),
		.item      (item),
		.idle      (ctrl_idle),
		.req       (alu_req),
		.rsp       (alu_rsp),
		.res_valid (res_valid),
		.res       (res)
	);

	dms_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Result queue: decouple the sequencer from a stalled master side
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(res_valid) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			q_mem[wr_ptr_q] <= res;
	end

	assign q_head   = q_mem[rd_ptr_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {1'b0, q_head.moved, q_head.reply_code, q_head.drive};
	assign m_tlast  = q_head.last;

`ifndef ASSERT_OFF
	// Acceptance gating must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cnt_q != (QAW+1)'(QDEPTH)))
		else $error("result queue written while full");

	// An accepted item keeps the sequencer busy on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_tready)
		else $error("input taken twice back to back");

	// Only real direction patterns are ever driven
	a_drive_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] == DRIVE_OFF || m_tdata[3:0] == DRIVE_FWD ||
		              m_tdata[3:0] == DRIVE_BACK || m_tdata[3:0] == DRIVE_RIGHT ||
		              m_tdata[3:0] == DRIVE_LEFT))
		else $error("illegal drive pattern");

	// Distance done is only reported with skipped or blocked replies
	a_moved_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[22:7] != '0) |->
		(m_tdata[6:4] == RC_SKIPPED || m_tdata[6:4] == RC_BLOCKED))
		else $error("moved set on a reply that carries none");
`endif

endmodule

[bench/drive_move_supervisor_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the drive move supervisor: directed cases, then random traffic.
module drive_move_supervisor_top_tb;
	import dms_pkg::*;

	// Ops beyond stop: both must come back as an invalid command
	localparam logic [2:0]  OP_UNKNOWN    = 3'd5;
	localparam logic [2:0]  OP_SPARE      = 3'd7;
	localparam logic [63:0] YAW_CEIL      = 64'hFFFF_FFFF_FFFF;
	// Give the sequencer room to finish the longest command before config writes
	localparam int          SETTLE_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	drive_move_supervisor_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Mirror of the supervisor: config copy and move state
	logic [7:0]         ppu_cfg;
	logic signed [10:0] bias_cfg;
	logic [2:0]         run_op;
	logic               run_reply;
	logic               obst_seen;
	logic [31:0]        right_edges;
	logic [31:0]        left_edges;
	logic [31:0]        edge_goal;
	logic [15:0]        deg_goal;
	logic [63:0]        yaw_acc;

	// Replies still owed by the block, oldest first
	res_t awaited_results[$];
	res_t got_item;
	res_t head_item;

	int sender_gap_pct;
	int reply_stall_pct;
	int items_sent;
	int fault_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#6_000_000;
		$display("status: fail");
		$finish;
	end

	// Receiver side: stall at random, redrawn every cycle
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= reply_stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// A zero register acts as one edge per cm
	function automatic logic [31:0] edges_per_cm();
		return (ppu_cfg == 8'd0) ? 32'd1 : {24'd0, ppu_cfg};
	endfunction

	// Distance covered so far: mean of both counters, saturating to 16 bits
	function automatic logic [15:0] cm_done();
		logic [63:0] d;
		d = (({32'd0, right_edges} + {32'd0, left_edges}) / 64'd2) / {32'd0, edges_per_cm()};
		return (d > 64'd65535) ? 16'hFFFF : d[15:0];
	endfunction

	// Whole degrees turned so far, saturating to 16 bits
	function automatic logic [15:0] deg_done();
		logic [63:0] d;
		d = yaw_acc / {47'd0, ANGLE_SCALE};
		return (d > 64'd65535) ? 16'hFFFF : d[15:0];
	endfunction

	function automatic logic [3:0] motor_enables(input logic [2:0] op);
		case (op)
			OP_FWD:   return DRIVE_FWD;
			OP_BACK:  return DRIVE_BACK;
			OP_RIGHT: return DRIVE_RIGHT;
			OP_LEFT:  return DRIVE_LEFT;
			default:  return DRIVE_OFF;
		endcase
	endfunction

	// Drop the running op and clear counters, goals and yaw
	function automatic void stop_motion();
		run_op      = OP_IDLE;
		run_reply   = 1'b0;
		right_edges = '0;
		left_edges  = '0;
		edge_goal   = '0;
		deg_goal    = '0;
		yaw_acc     = '0;
	endfunction

	function automatic res_t reply_of(input logic [2:0] code, input logic [15:0] mv);
		res_t r;
		r            = '0;
		r.reply_code = code;
		r.moved      = mv;
		return r;
	endfunction

	// Work out the replies of one accepted item and queue them
	function automatic void predict_results(input item_t it);
		res_t        outs[$];
		res_t        r;
		logic [3:0]  drv;
		int          rate;
		int          mag;
		logic [63:0] inc;

		if (it.kind == KIND_CMD) begin
			// Preempt a running move or turn, with a skipped reply if one is wanted
			if (run_op <= OP_LEFT) begin
				if (run_reply)
					outs.push_back(reply_of(RC_SKIPPED,
						(run_op <= OP_BACK) ? cm_done() : deg_done()));
			end
			stop_motion();
			if (it.command_op > OP_STOP) begin
				outs.push_back(reply_of(RC_INVALID, 16'd0));
			end else if (it.command_op != OP_STOP && it.amount == 16'd0) begin
				outs.push_back(reply_of(RC_MISSING, 16'd0));
			end else if (it.command_op == OP_FWD && obst_seen) begin
				if (it.want_reply)
					outs.push_back(reply_of(RC_BLOCKED, 16'd0));
			end else if (it.command_op == OP_STOP) begin
				if (it.want_reply)
					outs.push_back(reply_of(RC_SUCCESS, 16'd0));
			end else begin
				run_op    = it.command_op;
				run_reply = it.want_reply;
				if (it.command_op <= OP_BACK)
					edge_goal = {16'd0, it.amount} * edges_per_cm();
				else
					deg_goal = it.amount;
			end
		end else begin
			case (it.kind)
				KIND_ENC: begin
					if (it.encoder_side) begin
						if (left_edges != 32'hFFFF_FFFF)
							left_edges = left_edges + 32'd1;
					end else begin
						if (right_edges != 32'hFFFF_FFFF)
							right_edges = right_edges + 32'd1;
					end
				end
				KIND_GYRO: begin
					rate = $signed(it.gyro_rate) - $signed(bias_cfg);
					mag  = (rate < 0) ? -rate : rate;
					inc  = mag;
					inc  = inc * {54'd0, it.elapsed_ms};
					yaw_acc = (inc > YAW_CEIL - yaw_acc) ? YAW_CEIL : yaw_acc + inc;
				end
				default: obst_seen = it.obstacle;
			endcase
			// Goal reached first, then obstacle on a forward move, then yaw goal
			if (run_op <= OP_BACK && edge_goal != 0 &&
					right_edges >= edge_goal && left_edges >= edge_goal) begin
				if (run_reply)
					outs.push_back(reply_of(RC_SUCCESS, 16'd0));
				stop_motion();
			end else if (run_op == OP_FWD && obst_seen) begin
				if (run_reply)
					outs.push_back(reply_of(RC_BLOCKED, cm_done()));
				stop_motion();
			end else if ((run_op == OP_RIGHT || run_op == OP_LEFT) && deg_goal != 0 &&
					yaw_acc >= {48'd0, deg_goal} * {47'd0, ANGLE_SCALE}) begin
				if (run_reply)
					outs.push_back(reply_of(RC_SUCCESS, 16'd0));
				stop_motion();
			end
		end

		if (outs.size() == 0)
			outs.push_back(reply_of(RC_NONE, 16'd0));
		// Every reply of the item carries the enables left after it
		drv = motor_enables(run_op);
		foreach (outs[k]) begin
			r       = outs[k];
			r.drive = drv;
			r.last  = (k == outs.size() - 1);
			awaited_results.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------

	task automatic log_fault(input string what, input res_t want, input res_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t %s: expected drive=%h code=%0d moved=%0d last=%b, got drive=%h code=%0d moved=%0d last=%b",
				$realtime, what, want.drive, want.reply_code, want.moved, want.last,
				got.drive, got.reply_code, got.moved, got.last);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_item.drive      = m_tdata[3:0];
			got_item.reply_code = m_tdata[6:4];
			got_item.moved      = m_tdata[22:7];
			got_item.last       = m_tlast;
			if (awaited_results.size() == 0) begin
				log_fault("unexpected result", '0, got_item);
			end else begin
				head_item = awaited_results.pop_front();
				if (got_item.drive !== head_item.drive ||
						got_item.reply_code !== head_item.reply_code ||
						got_item.moved !== head_item.moved ||
						got_item.last !== head_item.last)
					log_fault("result mismatch", head_item, got_item);
			end
		end
	end

	// ---------------------------------------------------------------
	// Driving helpers
	// ---------------------------------------------------------------

	// Offer one item, idling first at random; valid stays high after the accept
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {it.obstacle, it.elapsed_ms, it.gyro_rate, it.encoder_side,
			it.want_reply, it.amount, it.command_op};
		do @(posedge clk); while (!s_tready);
		predict_results(it);
		items_sent++;
	endtask

	// Drop valid, hold until every owed reply is in, then let the block settle
	task automatic wait_drained(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write both registers on back-to-back cycles; only called while idle
	task automatic set_config(input logic [7:0] ppu, input logic signed [10:0] bias);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PPU;
		cfg_data  <= {3'd0, ppu};
		@(posedge clk);
		cfg_index <= REG_BIAS;
		cfg_data  <= bias;
		@(posedge clk);
		cfg_we   <= 1'b0;
		ppu_cfg  = ppu;
		bias_cfg = bias;
	endtask

	// Fields the kind does not use are left random
	function automatic item_t blank_item(input logic [1:0] kind);
		logic [63:0] r;
		item_t       it;
		r       = {$urandom(), $urandom()};
		it      = r[47:0];
		it.kind = kind;
		return it;
	endfunction

	task automatic send_cmd(input logic [2:0] op, input logic [15:0] amount, input logic want);
		item_t it;
		it            = blank_item(KIND_CMD);
		it.command_op = op;
		it.amount     = amount;
		it.want_reply = want;
		send_item(it);
	endtask

	task automatic send_edge(input logic side);
		item_t it;
		it              = blank_item(KIND_ENC);
		it.encoder_side = side;
		send_item(it);
	endtask

	task automatic send_gyro(input logic signed [15:0] rate, input logic [9:0] ms);
		item_t it;
		it            = blank_item(KIND_GYRO);
		it.gyro_rate  = rate;
		it.elapsed_ms = ms;
		send_item(it);
	endtask

	task automatic send_obstacle(input logic present);
		item_t it;
		it          = blank_item(KIND_OBST);
		it.obstacle = present;
		send_item(it);
	endtask

	// ---------------------------------------------------------------
	// Random scenarios
	// ---------------------------------------------------------------

	// Move command followed by a burst of edges sized to the goal, with some noise
	task automatic move_scenario();
		logic [15:0] amt;
		logic [31:0] goal;
		int          n;
		int          pick;

		amt = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(4, 1));
		send_cmd($urandom_range(1) ? OP_FWD : OP_BACK, amt, $urandom_range(1));
		goal = {16'd0, amt} * edges_per_cm();
		n    = (goal > 32'd14) ? 30 : 2 * int'(goal) + $urandom_range(3);
		repeat (n) begin
			pick = $urandom_range(23);
			if (pick == 0)
				send_obstacle($urandom_range(2) == 0);
			else if (pick == 1)
				send_item(blank_item(KIND_GYRO));
			else
				send_edge($urandom_range(1));
		end
	endtask

	// Turn command followed by gyro samples near the zero-rate offset
	task automatic turn_scenario();
		logic [15:0] amt;
		logic [9:0]  ms;
		int          rate;
		int          n;

		amt = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(20, 1));
		send_cmd($urandom_range(1) ? OP_RIGHT : OP_LEFT, amt, $urandom_range(1));
		n = $urandom_range(12, 1);
		repeat (n) begin
			if ($urandom_range(9) == 0) begin
				send_edge($urandom_range(1));
			end else begin
				if ($urandom_range(7) == 0)
					rate = $signed(16'($urandom()));
				else
					rate = int'(bias_cfg) + int'($urandom_range(8000)) - 4000;
				ms = ($urandom_range(15) == 0) ? 10'($urandom_range(1023)) :
					10'($urandom_range(1000));
				send_gyro(rate, ms);
			end
		end
	endtask

	// Stops, bad ops, missing amounts, obstacle changes and blocked forward starts
	task automatic misc_scenario();
		logic [2:0] op;

		case ($urandom_range(5))
			0, 1: send_obstacle($urandom_range(1));
			2: send_cmd(OP_STOP, $urandom(), $urandom_range(1));
			3: begin
				op = $urandom_range(OP_SPARE, OP_UNKNOWN);
				send_cmd(op, $urandom(), $urandom_range(1));
			end
			4: begin
				op = $urandom_range(OP_LEFT, OP_FWD);
				send_cmd(op, 16'd0, $urandom_range(1));
			end
			default: begin
				send_obstacle(1'b1);
				send_cmd(OP_FWD, $urandom_range(4, 1), $urandom_range(1));
			end
		endcase
	endtask

	task automatic random_traffic(input int n);
		int stop_at;
		int pick;

		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 40)
				move_scenario();
			else if (pick < 70)
				turn_scenario();
			else if (pick < 85)
				misc_scenario();
			else
				send_item(blank_item($urandom_range(3)));
			// Now and then hold the sender until every owed reply is back
			if ($urandom_range(19) == 0)
				wait_drained(0);
		end
	endtask

	task automatic traffic_phase(input logic [7:0] ppu, input logic signed [10:0] bias,
			input int n);
		wait_drained(SETTLE_CYCLES);
		set_config(ppu, bias);
		random_traffic(n);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset config: stop, bad ops, missing amounts, blocked start, preemption, turn done
	task automatic test_command_checks();
		send_cmd(OP_STOP, 16'hFFFF, 1'b0);
		send_cmd(OP_STOP, 16'd0, 1'b1);
		send_cmd(OP_UNKNOWN, 16'd5, 1'b1);
		send_cmd(OP_SPARE, 16'd9, 1'b0);
		send_cmd(OP_FWD, 16'd0, 1'b1);
		send_cmd(OP_LEFT, 16'd0, 1'b0);
		// Obstacle refuses forward but not backward
		send_obstacle(1'b1);
		send_cmd(OP_FWD, 16'd5, 1'b1);
		send_cmd(OP_BACK, 16'd1, 1'b1);
		send_edge(1'b0);
		send_obstacle(1'b0);
		// Turn preempts the backward move; one second at 131 above the offset is one degree
		send_cmd(OP_RIGHT, 16'd1, 1'b1);
		send_gyro(16'sd192, 10'd1000);
	endtask

	// One edge per cm: move to success, then a move cut short by an obstacle
	task automatic test_move_replies();
		wait_drained(SETTLE_CYCLES);
		set_config(8'd1, $signed(BIAS_RESET));
		send_cmd(OP_FWD, 16'd2, 1'b1);
		send_edge(1'b0);
		send_edge(1'b1);
		send_edge(1'b0);
		send_edge(1'b1);
		send_cmd(OP_FWD, 16'd3, 1'b1);
		send_edge(1'b0);
		send_edge(1'b1);
		send_edge(1'b1);
		send_obstacle(1'b1);
		send_obstacle(1'b0);
	endtask

	// Largest amounts and gyro extremes, then preempt with partial progress
	task automatic test_field_extremes();
		send_cmd(OP_LEFT, 16'hFFFF, 1'b1);
		send_gyro(16'sh8000, 10'h3FF);
		send_gyro(16'sh7FFF, 10'd1000);
		send_cmd(OP_BACK, 16'hFFFF, 1'b1);
		send_edge(1'b1);
		send_cmd(OP_STOP, 16'h1234, 1'b0);
	endtask

	task automatic test_traffic_slow_reader();
		sender_gap_pct  = 36;
		reply_stall_pct = 88;
		traffic_phase(8'd1, 11'sh400, 120);
		traffic_phase(8'd2, 11'sh3FF, 60);
	endtask

	task automatic test_traffic_slow_writer();
		sender_gap_pct  = 88;
		reply_stall_pct = 36;
		traffic_phase(8'd0, 11'sd0, 120);
		traffic_phase(8'd3, -11'sd300, 50);
	endtask

	task automatic test_traffic_full_rate();
		sender_gap_pct  = 0;
		reply_stall_pct = 0;
		traffic_phase(8'd255, $signed(BIAS_RESET), 80);
		traffic_phase(8'd1, 11'sd500, 120);
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_PPU;
		cfg_data        = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = KIND_CMD;
		sender_gap_pct  = 36;
		reply_stall_pct = 88;
		items_sent      = 0;
		fault_count     = 0;
		ppu_cfg         = PPU_RESET;
		bias_cfg        = BIAS_RESET;
		obst_seen       = 1'b0;
		stop_motion();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_command_checks();
		test_move_replies();
		test_field_extremes();
		test_traffic_slow_reader();
		test_traffic_slow_writer();
		test_traffic_full_rate();

		// Hold until the last reply is in, then give stray results a chance to show
		wait_drained(SETTLE_CYCLES);
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
